// ===== rtl/sqa_metropolis_spin_trial_macros.svh =====
`ifndef SQA_METROPOLIS_SPIN_TRIAL_MACROS_SVH
`define SQA_METROPOLIS_SPIN_TRIAL_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SQA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sqa assertion failed");

// next-cycle implication
`define SQA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sqa assertion failed");

`endif

// ===== rtl/sqa_pkg.sv =====
`default_nettype none
package sqa_pkg;

   localparam int MAX_SPINS    = 64;
   localparam int MAX_REPLICAS = 16;
   localparam int SPIN_AW      = $clog2(MAX_SPINS);
   localparam int REP_AW       = $clog2(MAX_REPLICAS);
   localparam int SCNT_W       = 7;
   localparam int RCNT_W       = 5;
   localparam int FSCALE_W     = 19;
   localparam int Q_W          = 32;
   localparam int E_W          = 44;
   localparam int ACC_W        = 48;
   localparam int CSR_AW       = 3;

   typedef enum logic [2:0] {
      ACT_FIELD  = 3'd0,
      ACT_COUP   = 3'd1,
      ACT_SPIN   = 3'd2,
      ACT_TRIAL  = 3'd3,
      ACT_ENERGY = 3'd4
   } act_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SPIN_COUNT    = 3'd0,
      CSR_REPLICA_COUNT = 3'd1,
      CSR_FIELD_SCALE   = 3'd2,
      CSR_TRANS_COEF    = 3'd3,
      CSR_ENERGY_OFFSET = 3'd4
   } csr_type;

   typedef enum logic [2:0] {
      RD_NONE, RD_SELF, RD_LEFT, RD_RIGHT, RD_UP, RD_DOWN, RD_EROW, RD_EPAIR
   } rd_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_FIELD, WR_COUP, WR_SPIN, WR_FLIP
   } wr_type;

   typedef enum logic [2:0] {
      RES_NONE, RES_OK, RES_ERR, RES_SPIN, RES_TRIAL, RES_ENERGY
   } res_type;

   typedef enum logic [1:0] {
      CALC_NONE, CALC_LOCAL, CALC_MULT
   } calc_type;

   typedef struct packed {
      logic [2:0]              action;
      logic [SPIN_AW-1:0]      spin_index;
      logic [SPIN_AW-1:0]      partner_index;
      logic [REP_AW-1:0]       replica;
      logic signed [Q_W-1:0]   load_value;
      logic                    spin_up;
      logic [Q_W-1:0]          accept_threshold;
   } req_type;

   typedef struct packed {
      logic                    flipped;
      logic                    spin_now;
      logic signed [E_W-1:0]   energy;
      logic                    status;
   } rsp_type;

   typedef struct packed {
      logic                take;
      rd_type              rd;
      wr_type              wr;
      res_type             res;
      calc_type            calc;
      logic                acc_clr;
      logic                push;
      logic [SPIN_AW-1:0]  ei;
      logic [SPIN_AW-1:0]  ej;
   } cmd_type;

   typedef struct packed {
      logic [2:0]          action;
      logic                x_ok;
      logic                p_ok;
      logic                y_ok;
      logic [SCNT_W-1:0]   n;
      logic                out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/sqa_ram.sv =====
`default_nettype none
module sqa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/sqa_dpath.sv =====
`default_nettype none
module sqa_dpath
   import sqa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_data,
   input  wire logic               rsp_ready,
   output      logic               rsp_valid,
   output      rsp_type            rsp_data,
   input  wire logic               csr_we,
   input  wire logic [CSR_AW-1:0]  csr_index,
   input  wire logic [Q_W-1:0]     csr_wdata,
   input  wire cmd_type            cmd,
   output      stat_type           st
);
   localparam int GA_W = REP_AW + SPIN_AW;
   localparam int CA_W = 2 * SPIN_AW;
   localparam int L_W  = Q_W + 2;
   localparam int P_W  = L_W + FSCALE_W + 1;
   localparam int D_W  = Q_W + 8;

   logic [SCNT_W-1:0]   spin_count_ff;
   logic [RCNT_W-1:0]   replica_count_ff;
   logic [FSCALE_W-1:0] field_scale_ff;
   logic signed [Q_W-1:0] trans_coef_ff, energy_offset_ff;
   req_type             item_ff;
   rd_type              tag_ff;
   logic                s_ff, sl_ff, sr_ff, su_ff, sd_ff, si_ff;
   logic signed [Q_W-1:0] h_ff, jl_ff, jr_ff;
   logic signed [L_W-1:0] local_ff;
   logic signed [P_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   rsp_type             res_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic [SCNT_W-1:0]   n;
   logic [RCNT_W-1:0]   m;
   logic [SPIN_AW-1:0]  x, p, xl, xr;
   logic [REP_AW-1:0]   y, yl, yr;
   logic [SCNT_W-1:0]   x1;
   logic [RCNT_W-1:0]   y1;
   logic                spin_we, spin_wd, spin_rd;
   logic [GA_W-1:0]     spin_wa, spin_ra;
   logic                field_we;
   logic [SPIN_AW-1:0]  field_ra;
   logic [Q_W-1:0]      field_rd;
   logic                coup_we;
   logic [CA_W-1:0]     coup_ra;
   logic [Q_W-1:0]      coup_rd;
   logic signed [L_W-1:0] lsum, ljl, ljr;
   logic signed [D_W-1:0] q, term, de;
   logic                flip;
   logic signed [ACC_W:0] efull;
   logic signed [E_W-1:0] esat;
   logic signed [ACC_W-1:0] fh, fj;

   assign n  = (spin_count_ff > SCNT_W'(MAX_SPINS)) ? SCNT_W'(MAX_SPINS) : spin_count_ff;
   assign m  = (replica_count_ff > RCNT_W'(MAX_REPLICAS)) ?
               RCNT_W'(MAX_REPLICAS) : replica_count_ff;
   assign x  = item_ff.spin_index;
   assign p  = item_ff.partner_index;
   assign y  = item_ff.replica;
   assign x1 = SCNT_W'(x) + SCNT_W'(1);
   assign y1 = RCNT_W'(y) + RCNT_W'(1);
   assign xl = (x == '0) ? SPIN_AW'(n - SCNT_W'(1)) : SPIN_AW'(x - SPIN_AW'(1));
   assign xr = (x1 == n) ? '0 : SPIN_AW'(x1);
   assign yl = (y == '0) ? REP_AW'(m - RCNT_W'(1)) : REP_AW'(y - REP_AW'(1));
   assign yr = (y1 == m) ? '0 : REP_AW'(y1);

   assign st.action   = item_ff.action;
   assign st.x_ok     = SCNT_W'(x) < n;
   assign st.p_ok     = SCNT_W'(p) < n;
   assign st.y_ok     = RCNT_W'(y) < m;
   assign st.n        = n;
   assign st.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      spin_ra  = {y, x};
      field_ra = x;
      coup_ra  = {x, xl};
      case (cmd.rd)
         RD_LEFT: begin
            spin_ra = {y, xl};
            coup_ra = {x, xr};
         end
         RD_RIGHT: spin_ra = {y, xr};
         RD_UP:    spin_ra = {yl, x};
         RD_DOWN:  spin_ra = {yr, x};
         RD_EROW: begin
            spin_ra  = {REP_AW'(0), cmd.ei};
            field_ra = cmd.ei;
         end
         RD_EPAIR: begin
            spin_ra = {REP_AW'(0), cmd.ej};
            coup_ra = {cmd.ei, cmd.ej};
         end
         default: ;
      endcase
   end

   // trial arithmetic
   assign ljl  = sl_ff ? L_W'(jl_ff) : -L_W'(jl_ff);
   assign ljr  = sr_ff ? L_W'(jr_ff) : -L_W'(jr_ff);
   assign lsum = L_W'(h_ff) + ljl + ljr;
   assign q    = D_W'($signed(prod_ff[P_W-1:16]));
   assign term = (su_ff != sd_ff) ? '0 :
                 (s_ff == su_ff) ? (D_W'(trans_coef_ff) <<< 1) : -(D_W'(trans_coef_ff) <<< 1);
   assign de   = q - term;
   assign flip = de < $signed({8'b0, item_ff.accept_threshold});

   assign spin_we = (cmd.wr == WR_SPIN) || ((cmd.wr == WR_FLIP) && flip);
   assign spin_wd = (cmd.wr == WR_SPIN) ? item_ff.spin_up : !s_ff;
   assign spin_wa = {y, x};
   assign field_we = cmd.wr == WR_FIELD;
   assign coup_we  = cmd.wr == WR_COUP;

   sqa_ram #(.WIDTH(1), .DEPTH(MAX_SPINS * MAX_REPLICAS)) u_spin (
      .clock(clock), .wr_en(spin_we), .wr_addr(spin_wa), .wr_data(spin_wd),
      .rd_addr(spin_ra), .rd_data(spin_rd)
   );
   sqa_ram #(.WIDTH(Q_W), .DEPTH(MAX_SPINS)) u_field (
      .clock(clock), .wr_en(field_we), .wr_addr(x), .wr_data(item_ff.load_value),
      .rd_addr(field_ra), .rd_data(field_rd)
   );
   sqa_ram #(.WIDTH(Q_W), .DEPTH(MAX_SPINS * MAX_SPINS)) u_coup (
      .clock(clock), .wr_en(coup_we), .wr_addr({x, p}), .wr_data(item_ff.load_value),
      .rd_addr(coup_ra), .rd_data(coup_rd)
   );

   // energy
   assign fh    = ACC_W'($signed(field_rd));
   assign fj    = ACC_W'($signed(coup_rd));
   assign efull = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(energy_offset_ff);
   always_comb begin
      if (efull > $signed((ACC_W+1)'({1'b0, {(E_W-1){1'b1}}})))
         esat = {1'b0, {(E_W-1){1'b1}}};
      else if (efull < -$signed((ACC_W+1)'({1'b1, {(E_W-1){1'b0}}})))
         esat = {1'b1, {(E_W-1){1'b0}}};
      else
         esat = E_W'(efull);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_count_ff    <= SCNT_W'(64);
         replica_count_ff <= RCNT_W'(1);
         field_scale_ff   <= FSCALE_W'(131072);
         trans_coef_ff    <= '0;
         energy_offset_ff <= '0;
         tag_ff           <= RD_NONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SPIN_COUNT:    spin_count_ff    <= csr_wdata[SCNT_W-1:0];
               CSR_REPLICA_COUNT: replica_count_ff <= csr_wdata[RCNT_W-1:0];
               CSR_FIELD_SCALE:   field_scale_ff   <= csr_wdata[FSCALE_W-1:0];
               CSR_TRANS_COEF:    trans_coef_ff    <= csr_wdata;
               CSR_ENERGY_OFFSET: energy_offset_ff <= csr_wdata;
               default: ;
            endcase
         end
         tag_ff <= cmd.rd;
         if (cmd.push)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take)
         item_ff <= req_data;
      case (tag_ff)
         RD_SELF: begin
            s_ff  <= spin_rd;
            h_ff  <= field_rd;
            jl_ff <= coup_rd;
         end
         RD_LEFT: begin
            sl_ff <= spin_rd;
            jr_ff <= coup_rd;
         end
         RD_RIGHT: sr_ff <= spin_rd;
         RD_UP:    su_ff <= spin_rd;
         RD_DOWN:  sd_ff <= spin_rd;
         RD_EROW: begin
            si_ff  <= spin_rd;
            acc_ff <= acc_ff + (spin_rd ? fh : -fh);
         end
         RD_EPAIR: acc_ff <= acc_ff + ((si_ff == spin_rd) ? fj : -fj);
         default: ;
      endcase
      if (cmd.acc_clr)
         acc_ff <= '0;
      case (cmd.calc)
         CALC_LOCAL: local_ff <= s_ff ? lsum : -lsum;
         CALC_MULT:  prod_ff  <= P_W'(local_ff * $signed({1'b0, field_scale_ff}));
         default: ;
      endcase
      case (cmd.res)
         RES_OK:     res_ff <= '0;
         RES_ERR:    res_ff <= '{flipped: 1'b0, spin_now: 1'b0, energy: '0, status: 1'b1};
         RES_SPIN:   res_ff <= '{flipped: 1'b0, spin_now: item_ff.spin_up, energy: '0,
                                 status: 1'b0};
         RES_TRIAL:  res_ff <= '{flipped: flip, spin_now: flip ? !s_ff : s_ff, energy: '0,
                                 status: 1'b0};
         RES_ENERGY: res_ff <= '{flipped: 1'b0, spin_now: 1'b0, energy: esat, status: 1'b0};
         default: ;
      endcase
      if (cmd.push)
         rsp_data_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

// ===== rtl/sqa_ctrl.sv =====
`default_nettype none
`include "sqa_metropolis_spin_trial_macros.svh"
module sqa_ctrl
   import sqa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire stat_type st,
   output      cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_T_SELF, S_T_LEFT, S_T_RIGHT, S_T_UP, S_T_DOWN,
      S_T_LOCAL, S_T_MULT, S_T_DECIDE, S_E_WALK, S_E_DRAIN, S_E_DONE, S_RESULT
   } state_type;

   state_type         state_ff, state_in;
   logic [SCNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic              row_ff, row_in;
   logic [SCNT_W-1:0] i1, j1;

   assign i1 = i_ff + SCNT_W'(1);
   assign j1 = j_ff + SCNT_W'(1);
   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      row_in      = row_ff;
      cmd         = '0;
      cmd.rd      = RD_NONE;
      cmd.wr      = WR_NONE;
      cmd.res     = RES_NONE;
      cmd.calc    = CALC_NONE;
      cmd.ei      = i_ff[SPIN_AW-1:0];
      cmd.ej      = j_ff[SPIN_AW-1:0];
      cmd.take    = req_valid && req_ready;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            state_in = S_RESULT;
            cmd.res  = RES_ERR;
            case (st.action)
               ACT_FIELD: if (st.x_ok) begin
                  cmd.wr  = WR_FIELD;
                  cmd.res = RES_OK;
               end
               ACT_COUP: if (st.x_ok && st.p_ok) begin
                  cmd.wr  = WR_COUP;
                  cmd.res = RES_OK;
               end
               ACT_SPIN: if (st.x_ok && st.y_ok) begin
                  cmd.wr  = WR_SPIN;
                  cmd.res = RES_SPIN;
               end
               ACT_TRIAL: if (st.x_ok && st.y_ok) begin
                  cmd.res  = RES_NONE;
                  state_in = S_T_SELF;
               end
               ACT_ENERGY: begin
                  cmd.res     = RES_NONE;
                  cmd.acc_clr = 1'b1;
                  i_in        = '0;
                  row_in      = 1'b1;
                  state_in    = (st.n == '0) ? S_E_DRAIN : S_E_WALK;
               end
               default: ;
            endcase
         end
         S_T_SELF: begin
            cmd.rd   = RD_SELF;
            state_in = S_T_LEFT;
         end
         S_T_LEFT: begin
            cmd.rd   = RD_LEFT;
            state_in = S_T_RIGHT;
         end
         S_T_RIGHT: begin
            cmd.rd   = RD_RIGHT;
            state_in = S_T_UP;
         end
         S_T_UP: begin
            cmd.rd   = RD_UP;
            state_in = S_T_DOWN;
         end
         S_T_DOWN: begin
            cmd.rd   = RD_DOWN;
            state_in = S_T_LOCAL;
         end
         S_T_LOCAL: begin
            cmd.calc = CALC_LOCAL;
            state_in = S_T_MULT;
         end
         S_T_MULT: begin
            cmd.calc = CALC_MULT;
            state_in = S_T_DECIDE;
         end
         S_T_DECIDE: begin
            cmd.wr   = WR_FLIP;
            cmd.res  = RES_TRIAL;
            state_in = S_RESULT;
         end
         S_E_WALK: begin
            if (row_ff) begin
               cmd.rd = RD_EROW;
               if (i1 < st.n) begin
                  j_in   = i1;
                  row_in = 1'b0;
               end else begin
                  i_in     = i1;
                  state_in = S_E_DRAIN;
               end
            end else begin
               cmd.rd = RD_EPAIR;
               if (j1 < st.n) begin
                  j_in = j1;
               end else begin
                  i_in   = i1;
                  row_in = 1'b1;
                  if (i1 >= st.n) state_in = S_E_DRAIN;
               end
            end
         end
         S_E_DRAIN: state_in = S_E_DONE;
         S_E_DONE: begin
            cmd.res  = RES_ENERGY;
            state_in = S_RESULT;
         end
         S_RESULT: if (st.out_free) begin
            cmd.push = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         row_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         row_ff   <= row_in;
      end
   end

   `SQA_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)
   `SQA_ASSERT_IMP(a_push_room, cmd.push, st.out_free)
   `SQA_ASSERT_IMP(a_spin_wr_ok, cmd.wr == WR_SPIN, st.x_ok && st.y_ok)
   `SQA_ASSERT_IMP(a_coup_wr_ok, cmd.wr == WR_COUP, st.x_ok && st.p_ok)
endmodule
`default_nettype wire

// ===== rtl/sqa_metropolis_spin_trial.sv =====
// Metropolis spin trial engine for simulated quantum annealing. One item is taken at a time;
// its result lands in an output register, so the next item is accepted while that result
// waits. Load and error items go from decode straight to the result; a trial makes five spin
// reads through the single spin RAM port, then forms the local sum, multiplies and compares;
// an energy read walks every row and pair of the n spins in use, one spin and field or
// coupling fetch per cycle. Stores are not cleared at reset: write every field,
// coupling and spin entry before a trial or energy read uses it.
`default_nettype none
module sqa_metropolis_spin_trial
   import sqa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire req_type           req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      rsp_type           rsp_data,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_index,
   input  wire logic [Q_W-1:0]    csr_wdata
);
   cmd_type  cmd;
   stat_type st;

   sqa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .st(st), .cmd(cmd)
   );

   sqa_dpath u_dpath (
      .clock(clock), .reset(reset), .req_data(req_data), .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .cmd(cmd), .st(st)
   );
endmodule
`default_nettype wire
